// ===== rtl/core/lrc_pkg.sv =====
// Shared constants and types for the luma RMS contrast block.
// No dependencies; the top level, front end and back end refer to it by scoped names.
`default_nettype none
package lrc_pkg;

  localparam int unsigned MAX_PIXELS_DEF  = 4194304;
  localparam int unsigned RESULT_BITS_DEF = 16;

  // Q16 luma weights, summing to 65536
  localparam int unsigned W_RED   = 19595;
  localparam int unsigned W_GREEN = 38470;
  localparam int unsigned W_BLUE  = 7471;

  localparam int unsigned PIX_FIELD_BITS = 23;
  localparam int unsigned STD_FIELD_BITS = 16;
  localparam int unsigned STD_FIELD_MAX  = 65535;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SINGLE   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/lrc_pixel_if.sv =====
// Pixel channel: valid/ready handshake with the RGB payload and frame end mark.
// No dependencies.
`default_nettype none
interface lrc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lrc_result_if.sv =====
// Result channel: valid/ready handshake with the per-frame contrast result.
// No dependencies.
`default_nettype none
interface lrc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] std_dev;
  logic [22:0] pixels_seen;
  logic [1:0]  status;

  modport source (output valid, std_dev, pixels_seen, status, input ready);
  modport sink   (input valid, std_dev, pixels_seen, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/luma_rms_contrast.sv =====
// Luma RMS contrast: sample standard deviation of per-pixel luma over a frame.
// Pixels are taken at one per clock; the front end forms luma and accumulates the
// count, sum and sum of squares, and hands frame totals to a two-entry queue. The
// back end then works out one frame with a bit-serial multiplier (three products),
// a restoring divider and a 32-step square root. Pixel input stalls only when a
// frame end reaches the queue while two finished frames are already waiting.
`default_nettype none
module luma_rms_contrast #(
  parameter int unsigned MAX_PIXELS  = lrc_pkg::MAX_PIXELS_DEF,
  parameter int unsigned RESULT_BITS = lrc_pkg::RESULT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lrc_pixel_if.sink   pixel,
  lrc_result_if.source result
);

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned FW = 1 + CW + (CW + 16) + (CW + 32);

  logic          push_valid, push_ready, pop_valid, pop;
  logic [FW-1:0] push_data, pop_data;

  lrc_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  lrc_queue #(.W(FW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  lrc_back #(.MAX_PIXELS(MAX_PIXELS), .RESULT_BITS(RESULT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

// ===== rtl/core/lrc_front.sv =====
// Front end: luma per pixel, squaring, and frame accumulation.
// Uses lrc_pkg and lrc_pixel_if; pushes frame totals to lrc_queue.
`default_nettype none
module lrc_front #(
  parameter int unsigned MAX_PIXELS = lrc_pkg::MAX_PIXELS_DEF,
  localparam int unsigned CW   = $clog2(MAX_PIXELS + 1),
  localparam int unsigned SUMW = CW + 16,
  localparam int unsigned SQW  = CW + 32,
  localparam int unsigned FW   = 1 + CW + SUMW + SQW
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lrc_pixel_if.sink  pixel,
  output logic          push_valid,
  output logic [FW-1:0] push_data,
  input  wire logic     push_ready
);

  logic            enable;
  logic [31:0]     l_wide;
  logic [32:0]     y_round;
  logic            s1_valid, s1_last;
  logic [15:0]     s1_y;
  logic            s2_valid, s2_last;
  logic [15:0]     s2_y;
  logic [31:0]     s2_yy;
  logic [CW-1:0]   count, count_next;
  logic [SUMW-1:0] luma_sum, luma_sum_next;
  logic [SQW-1:0]  square_sum, square_sum_next;
  logic            overflow, overflow_next;
  logic            count_full;

  // whole pipe holds while a frame end waits for queue space
  assign enable      = !(s2_valid && s2_last && !push_ready);
  assign pixel.ready = enable;

  assign l_wide  = lrc_pkg::W_RED * 32'(pixel.red) + lrc_pkg::W_GREEN * 32'(pixel.green)
                 + lrc_pkg::W_BLUE * 32'(pixel.blue);
  assign y_round = 33'(l_wide[23:0]) + (33'(l_wide[23:0]) << 8) + 33'd32768;

  assign count_full      = (count == CW'(MAX_PIXELS));
  assign count_next      = count_full ? count : count + CW'(1);
  assign luma_sum_next   = count_full ? luma_sum : luma_sum + SUMW'(s2_y);
  assign square_sum_next = count_full ? square_sum : square_sum + SQW'(s2_yy);
  assign overflow_next   = overflow | count_full;

  assign push_valid = s2_valid && s2_last;
  assign push_data  = {overflow_next, count_next, luma_sum_next, square_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      count      <= '0;
      luma_sum   <= '0;
      square_sum <= '0;
      overflow   <= 1'b0;
    end else if (enable) begin
      s1_valid <= pixel.valid;
      s1_y     <= y_round[31:16];
      s1_last  <= pixel.last_pixel;
      s2_valid <= s1_valid;
      s2_y     <= s1_y;
      s2_yy    <= s1_y * s1_y;
      s2_last  <= s1_last;
      if (s2_valid) begin
        if (s2_last) begin
          count      <= '0;
          luma_sum   <= '0;
          square_sum <= '0;
          overflow   <= 1'b0;
        end else begin
          count      <= count_next;
          luma_sum   <= luma_sum_next;
          square_sum <= square_sum_next;
          overflow   <= overflow_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lrc_queue.sv =====
// Two-entry queue of frame totals between front and back ends.
// No package dependencies.
`default_nettype none
module lrc_queue #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  input  wire logic [W-1:0] push_data,
  output logic              push_ready,
  output logic              pop_valid,
  output logic [W-1:0]      pop_data,
  input  wire logic         pop
);

  logic [W-1:0] entries [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   fill;
  logic         do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        entries[wr_ptr] <= push_data;
        wr_ptr          <= !wr_ptr;
      end
      if (do_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lrc_back.sv =====
// Back end: per-frame variance and square root on serial units, one multiplier shared by all three products.
// Uses lrc_pkg and lrc_result_if; pops frame totals from lrc_queue.
`default_nettype none
module lrc_back #(
  parameter int unsigned MAX_PIXELS  = lrc_pkg::MAX_PIXELS_DEF,
  parameter int unsigned RESULT_BITS = lrc_pkg::RESULT_BITS_DEF,
  localparam int unsigned CW   = $clog2(MAX_PIXELS + 1),
  localparam int unsigned SUMW = CW + 16,
  localparam int unsigned SQW  = CW + 32,
  localparam int unsigned FW   = 1 + CW + SUMW + SQW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  input  wire logic [FW-1:0] pop_data,
  output logic               pop,
  lrc_result_if.source       result
);

  localparam int unsigned PW   = 2 * CW + 32;
  localparam int unsigned NW   = PW + 2 * RESULT_BITS;
  localparam int unsigned DW   = 2 * CW + 32;
  localparam int unsigned CNTW = $clog2(NW + 1);
  localparam int unsigned LIM  = (RESULT_BITS >= 16) ? lrc_pkg::STD_FIELD_MAX
                                                     : (1 << RESULT_BITS) - 1;

  lrc_pkg::back_state_t state, state_next;

  logic            in_ovf;
  logic [CW-1:0]   in_n;
  logic [SUMW-1:0] in_sum;
  logic [SQW-1:0]  in_sq;

  logic [CW-1:0]   n;
  logic            ovf;
  logic [SUMW-1:0] tsum;
  logic [PW-1:0]   mul_a, acc, acc_next, p1;
  logic [SUMW-1:0] mul_b;
  logic [1:0]      phase;
  logic [NW-1:0]   num, quo, quo_next;
  logic [DW-1:0]   den, rem, rem_next;
  logic [DW:0]     rem_sh;
  logic [NW+63:0]  quo_ext;
  logic [63:0]     sq_v, sq_res, sq_bit, v_sat;
  logic [64:0]     trial;
  logic [CNTW-1:0] cnt;
  logic            mul_last, div_last, sqrt_last, out_free;
  logic [CW+22:0]  n_ext;
  logic [63:0]     std_full;

  assign {in_ovf, in_n, in_sum, in_sq} = pop_data;

  assign mul_last  = (cnt == CNTW'(SUMW - 1));
  assign div_last  = (cnt == CNTW'(NW - 1));
  assign sqrt_last = (cnt == CNTW'(31));
  assign out_free  = !result.valid || result.ready;

  assign acc_next = mul_b[0] ? acc + mul_a : acc;

  // restoring division, one quotient bit a cycle
  assign rem_sh   = {rem, num[NW-1]};
  assign rem_next = (rem_sh >= {1'b0, den}) ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
  assign quo_next = {quo[NW-2:0], (rem_sh >= {1'b0, den})};
  assign quo_ext  = (NW + 64)'(quo_next);
  assign v_sat    = (|quo_ext[NW+63:64]) ? '1 : quo_ext[63:0];

  assign trial    = {1'b0, sq_res} + {1'b0, sq_bit};
  assign std_full = (sq_res > 64'(LIM)) ? 64'(LIM) : sq_res;
  assign n_ext    = (CW + 23)'(n);

  always_ff @(posedge clk) begin
    if (rst) state <= lrc_pkg::BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      lrc_pkg::BK_IDLE: begin
        if (pop_valid) begin
          pop        = 1'b1;
          state_next = (in_n < CW'(2)) ? lrc_pkg::BK_DONE : lrc_pkg::BK_MUL;
        end
      end
      lrc_pkg::BK_MUL:  if (mul_last && phase == 2'd2) state_next = lrc_pkg::BK_DIV;
      lrc_pkg::BK_DIV:  if (div_last) state_next = lrc_pkg::BK_SQRT;
      lrc_pkg::BK_SQRT: if (sqrt_last) state_next = lrc_pkg::BK_DONE;
      lrc_pkg::BK_DONE: if (out_free) state_next = lrc_pkg::BK_IDLE;
      default:          state_next = lrc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lrc_pkg::BK_IDLE: begin
        n      <= in_n;
        ovf    <= in_ovf;
        tsum   <= in_sum;
        mul_a  <= PW'(in_sq);
        mul_b  <= SUMW'(in_n);
        acc    <= '0;
        phase  <= 2'd0;
        cnt    <= '0;
        sq_res <= '0;
      end
      lrc_pkg::BK_MUL: begin
        if (mul_last) begin
          cnt   <= '0;
          acc   <= '0;
          phase <= phase + 2'd1;
          priority case (phase)
            2'd0: begin
              p1    <= acc_next;
              mul_a <= PW'(tsum);
              mul_b <= tsum;
            end
            2'd1: begin
              // sum of squares term minus squared sum, scaled for the fraction bits
              num   <= {p1 - acc_next, (2 * RESULT_BITS)'(0)};
              mul_a <= PW'(n);
              mul_b <= SUMW'(n - CW'(1));
            end
            default: begin
              den <= {acc_next[2*CW-1:0], 32'd0};
              rem <= '0;
              quo <= '0;
            end
          endcase
        end else begin
          cnt   <= cnt + CNTW'(1);
          acc   <= acc_next;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
        end
      end
      lrc_pkg::BK_DIV: begin
        rem <= rem_next;
        quo <= quo_next;
        num <= num << 1;
        if (div_last) begin
          cnt    <= '0;
          sq_v   <= v_sat;
          sq_res <= '0;
          sq_bit <= 64'd1 << 62;
        end else begin
          cnt <= cnt + CNTW'(1);
        end
      end
      lrc_pkg::BK_SQRT: begin
        cnt <= cnt + CNTW'(1);
        if ({1'b0, sq_v} >= trial) begin
          sq_v   <= sq_v - trial[63:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == lrc_pkg::BK_DONE && out_free) begin
      result.valid       <= 1'b1;
      result.std_dev     <= std_full[15:0];
      result.pixels_seen <= n_ext[22:0];
      result.status      <= ovf ? lrc_pkg::ST_OVERFLOW
                          : (n < CW'(2)) ? lrc_pkg::ST_SINGLE : lrc_pkg::ST_OK;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
